// ----- src/belim_pkg.sv -----
package belim_pkg;

    // Fixed-point format and energy range.
    localparam int FRAC_BITS  = 8;
    localparam int ENERGY_MAX = 60;

    // Cap in power units: up to 125 W, so seven integer bits.
    localparam int CAP_W = FRAC_BITS + 7;
    // Widest unsigned power quantity (cap or a 16-bit register value).
    localparam int MAXW  = (CAP_W > 16) ? CAP_W : 16;
    // Signed working width: sums and differences of two power quantities.
    localparam int DW    = MAXW + 3;
    // Product width: signed DW operand times unsigned 16-bit operand.
    localparam int PW    = DW + 16;

    // Square-root table, Q.FRAC_BITS, indexed by whole joules.
    localparam int ROOT_W    = FRAC_BITS + 4;
    localparam int TAB_DEPTH = ((ENERGY_MAX > 63) ? ENERGY_MAX : 63) + 1;
    localparam int TAB_IW    = $clog2(TAB_DEPTH);

    typedef logic [ROOT_W-1:0] t_root_tab [TAB_DEPTH];

    // Rounded-to-nearest square root of each table index, built at elaboration.
    function automatic t_root_tab f_build_roots();
        t_root_tab       tab;
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        for (int e = 0; e < TAB_DEPTH; e++) begin
            x = 64'(e) << (2 * FRAC_BITS);
            r = 64'd0;
            b = 64'h4000_0000_0000_0000;
            while (b > x) begin
                b = b >> 2;
            end
            while (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            if (x > r) begin
                r = r + 64'd1;
            end
            tab[e] = r[ROOT_W-1:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = f_build_roots();

    // Cap limits and reset values in power units.
    localparam int CAP_MIN_W   = 35;
    localparam int CAP_MAX_W   = 125;
    localparam int CAP_RESET_W = 60;

    localparam logic signed [DW-1:0] CAP_MIN_P = DW'(longint'(CAP_MIN_W) << FRAC_BITS);
    localparam logic signed [DW-1:0] CAP_MAX_P = DW'(longint'(CAP_MAX_W) << FRAC_BITS);
    localparam logic [CAP_W-1:0]     CAP_RESET = CAP_W'(longint'(CAP_RESET_W) << FRAC_BITS);

    localparam longint unsigned OFFLINE_COEF_RST = 55706;

    localparam logic signed [DW-1:0] HBP_RESET =
        DW'(((longint'(CAP_RESET_W) << FRAC_BITS) * longint'(OFFLINE_COEF_RST)) >>> 16);
    localparam logic signed [DW-1:0] FILT_RESET =
        DW'(longint'(HBP_RESET) - (longint'(CAP_RESET_W) << FRAC_BITS));

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_LOOP_GAIN      = 3'd0,
        REG_ENERGY_TARGET  = 3'd1,
        REG_RISE_ALPHA     = 3'd2,
        REG_FALL_ALPHA     = 3'd3,
        REG_MAX_BONUS      = 3'd4,
        REG_BOOSTER_BONUS  = 3'd5,
        REG_MIN_POWER_COEF = 3'd6,
        REG_OFFLINE_COEF   = 3'd7
    } t_reg_idx;

    // Configuration reset values.
    localparam logic [15:0] LOOP_GAIN_RST      = 16'd3072;
    localparam logic [5:0]  ENERGY_TARGET_RST  = 6'd30;
    localparam logic [15:0] RISE_ALPHA_RST     = 16'd655;
    localparam logic [15:0] FALL_ALPHA_RST     = 16'd13107;
    localparam logic [14:0] MAX_BONUS_RST      = 15'd5120;
    localparam logic [15:0] BOOSTER_BONUS_RST  = 16'd25600;
    localparam logic [15:0] MIN_POWER_COEF_RST = 16'd49152;
    localparam logic [15:0] OFFLINE_COEF_RSTV  = 16'(OFFLINE_COEF_RST);

    // Item payloads.
    typedef struct packed {
        logic        link_online;
        logic [15:0] raw_power_cap;
        logic [15:0] raw_buffer_energy;
        logic        booster_active;
    } t_in_item;

    typedef struct packed {
        logic [16:0] drive_power_limit;
        logic [14:0] base_power_cap;
        logic [15:0] buffered_power;
    } t_out_item;

    // Microcode fields.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_CAPMIN,
        MUL_GAIN,
        MUL_STEP,
        MUL_CAPOFF,
        MUL_FLOOR
    } t_mul_sel;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_LOADJ,
        ALU_TARGET,
        ALU_FILT,
        ALU_HBP_ON,
        ALU_OFF,
        ALU_LOMIN,
        ALU_LIMIT
    } t_alu_op;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_IF_OFFLINE,
        JMP_DONE
    } t_jump;

    localparam int UC_STEPS = 11;
    localparam int PC_W     = $clog2(UC_STEPS);

    // Step addresses of the control program.
    localparam logic [PC_W-1:0] UC_CHECK   = PC_W'(0);
    localparam logic [PC_W-1:0] UC_CAPMIN  = PC_W'(1);
    localparam logic [PC_W-1:0] UC_GAIN    = PC_W'(2);
    localparam logic [PC_W-1:0] UC_TARGET  = PC_W'(3);
    localparam logic [PC_W-1:0] UC_STEP    = PC_W'(4);
    localparam logic [PC_W-1:0] UC_FILT    = PC_W'(5);
    localparam logic [PC_W-1:0] UC_HBP_ON  = PC_W'(6);
    localparam logic [PC_W-1:0] UC_OFFMUL  = PC_W'(7);
    localparam logic [PC_W-1:0] UC_OFFSET  = PC_W'(8);
    localparam logic [PC_W-1:0] UC_LOMIN   = PC_W'(9);
    localparam logic [PC_W-1:0] UC_LIMIT   = PC_W'(10);

    typedef struct packed {
        t_mul_sel        mul;
        t_alu_op         alu;
        t_jump           jmp;
        logic [PC_W-1:0] dest;
    } t_uword;

    function automatic t_uword f_uw(input t_mul_sel m, input t_alu_op a,
                                    input t_jump j, input logic [PC_W-1:0] d);
        t_uword w;
        w.mul  = m;
        w.alu  = a;
        w.jmp  = j;
        w.dest = d;
        return w;
    endfunction

    // Control program. An ALU op that uses a product consumes the latest product
    // that an earlier multiplying step registered.
    function automatic t_uword f_ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = f_uw(MUL_NONE, ALU_NONE, JMP_DONE, UC_CHECK);
        case (pc)
            UC_CHECK:  w = f_uw(MUL_NONE,   ALU_NONE,   JMP_IF_OFFLINE, UC_OFFMUL);
            UC_CAPMIN: w = f_uw(MUL_CAPMIN, ALU_NONE,   JMP_NEXT,       UC_CHECK);
            UC_GAIN:   w = f_uw(MUL_GAIN,   ALU_LOADJ,  JMP_NEXT,       UC_CHECK);
            UC_TARGET: w = f_uw(MUL_NONE,   ALU_TARGET, JMP_NEXT,       UC_CHECK);
            UC_STEP:   w = f_uw(MUL_STEP,   ALU_NONE,   JMP_NEXT,       UC_CHECK);
            UC_FILT:   w = f_uw(MUL_FLOOR,  ALU_FILT,   JMP_NEXT,       UC_CHECK);
            UC_HBP_ON: w = f_uw(MUL_NONE,   ALU_HBP_ON, JMP_GOTO,       UC_LOMIN);
            UC_OFFMUL: w = f_uw(MUL_CAPOFF, ALU_NONE,   JMP_NEXT,       UC_CHECK);
            UC_OFFSET: w = f_uw(MUL_FLOOR,  ALU_OFF,    JMP_NEXT,       UC_CHECK);
            UC_LOMIN:  w = f_uw(MUL_NONE,   ALU_LOMIN,  JMP_NEXT,       UC_CHECK);
            UC_LIMIT:  w = f_uw(MUL_NONE,   ALU_LIMIT,  JMP_DONE,       UC_CHECK);
            default:   w = f_uw(MUL_NONE,   ALU_NONE,   JMP_DONE,       UC_CHECK);
        endcase
        return w;
    endfunction

endpackage

// ----- src/belim_in_if.sv -----
interface belim_in_if import belim_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/belim_out_if.sv -----
interface belim_out_if import belim_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/buffer_energy_power_limiter_core.sv -----
// Buffer-energy chassis power limiter. One input item per control tick gives
// one result item. The block works on one item at a time: a short control
// program steps a single shared multiplier and an adder/clamp unit, so an
// online item passes a load, then nine program steps, on its way to the output
// register, and an offline item a load, then five program steps. The
// next item is accepted in the cycle after the result is written, while the
// result may still wait in the output register. The result step stalls only
// when the output register still holds an earlier result that is not taken.
// Configuration writes are taken at any cycle and must happen while idle.
module buffer_energy_power_limiter_core import belim_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    belim_in_if.sink          i_in,
    belim_out_if.source       o_out,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    // Control and configuration registers.
    logic             r_busy, n_busy;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_loop_gain, n_loop_gain;
    logic [5:0]       r_energy_target, n_energy_target;
    logic [15:0]      r_rise_alpha, n_rise_alpha;
    logic [15:0]      r_fall_alpha, n_fall_alpha;
    logic [14:0]      r_max_bonus, n_max_bonus;
    logic [15:0]      r_booster_bonus, n_booster_bonus;
    logic [15:0]      r_min_power_coef, n_min_power_coef;
    logic [15:0]      r_offline_coef, n_offline_coef;

    // Block state.
    logic [CAP_W-1:0]      r_cap, n_cap;
    logic signed [DW-1:0]  r_filt, n_filt;
    logic signed [DW-1:0]  r_hbp, n_hbp;

    // Datapath registers.
    logic signed [PW-1:0]     r_prod, n_prod;
    logic signed [ROOT_W:0]   r_err, n_err;
    logic signed [DW-1:0]     r_lo, n_lo;
    logic signed [DW-1:0]     r_tgt, n_tgt;
    logic signed [DW-1:0]     r_lomin, n_lomin;
    logic                     r_online, n_online;
    logic                     r_boost, n_boost;
    t_out_item                r_out_data, n_out_data;

    // Combinational helpers.
    t_uword                w_uw;
    logic                  w_accept;
    logic                  w_stall;
    logic [6:0]            w_cap_w;
    logic [TAB_IW-1:0]     w_energy;
    logic [TAB_IW-1:0]     w_target_idx;
    logic signed [DW-1:0]  w_cap_dw;
    logic signed [DW-1:0]  w_mb_dw;
    logic signed [DW-1:0]  w_bb_dw;
    logic signed [DW-1:0]  w_err_dw;
    logic signed [DW-1:0]  w_mul_a;
    logic [15:0]           w_mul_b;
    logic signed [PW-1:0]  w_prod;
    logic signed [PW-1:0]  w_tw;
    logic signed [PW-1:0]  w_lo_pw;
    logic signed [PW-1:0]  w_mb_pw;
    logic signed [PW-1:0]  w_step_pw;
    logic signed [PW-1:0]  w_shr16;
    logic signed [DW-1:0]  w_sum;
    logic signed [DW-1:0]  w_sum_lo;
    logic signed [DW-1:0]  w_sum_hi;
    logic signed [DW-1:0]  w_lim_v;
    logic signed [DW-1:0]  w_lim_hi;
    logic signed [DW-1:0]  w_lim;
    logic signed [DW-1:0]  w_neg_filt;

    assign w_uw      = f_ucode(r_pc);
    assign i_in.ready = !r_busy;
    assign w_accept  = i_in.valid && !r_busy;
    assign w_stall   = r_busy && (w_uw.jmp == JMP_DONE) && r_out_valid && !o_out.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Zero-extended views of unsigned quantities, and the sign-extended error, in the signed working width.
    assign w_cap_dw = {{(DW-CAP_W){1'b0}}, r_cap};
    assign w_mb_dw  = {{(DW-15){1'b0}}, r_max_bonus};
    assign w_bb_dw  = {{(DW-16){1'b0}}, r_booster_bonus};
    assign w_err_dw = DW'(r_err);

    // Input clamps: cap to the legal range, energy to the table range.
    always_comb begin
        if (i_in.data.raw_power_cap < 16'(CAP_MIN_W)) begin
            w_cap_w = 7'(CAP_MIN_W);
        end else if (i_in.data.raw_power_cap > 16'(CAP_MAX_W)) begin
            w_cap_w = 7'(CAP_MAX_W);
        end else begin
            w_cap_w = i_in.data.raw_power_cap[6:0];
        end
        if (i_in.data.raw_buffer_energy > 16'(ENERGY_MAX)) begin
            w_energy = TAB_IW'(ENERGY_MAX);
        end else begin
            w_energy = i_in.data.raw_buffer_energy[TAB_IW-1:0];
        end
        w_target_idx = TAB_IW'(r_energy_target);
    end

    // Shared multiplier operand selection.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (w_uw.mul)
            MUL_NONE: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
            MUL_CAPMIN: begin
                w_mul_a = w_cap_dw;
                w_mul_b = r_min_power_coef;
            end
            MUL_GAIN: begin
                w_mul_a = w_err_dw;
                w_mul_b = r_loop_gain;
            end
            MUL_STEP: begin
                w_mul_a = r_tgt - r_filt;
                w_mul_b = (r_tgt < r_filt) ? r_fall_alpha : r_rise_alpha;
            end
            MUL_CAPOFF: begin
                w_mul_a = w_cap_dw;
                w_mul_b = r_offline_coef;
            end
            MUL_FLOOR: begin
                w_mul_a = CAP_MIN_P;
                w_mul_b = r_min_power_coef;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * $signed({1'b0, w_mul_b});

    // Product views and clamp operands for the ALU ops.
    assign w_shr16    = r_prod >>> 16;
    assign w_tw       = r_prod >>> 8;
    assign w_lo_pw    = PW'(r_lo);
    assign w_mb_pw    = PW'(w_mb_dw);
    assign w_step_pw  = (r_prod + $signed(PW'(32768))) >>> 16;
    assign w_sum      = w_cap_dw + r_filt;
    assign w_sum_lo   = w_cap_dw + r_lo;
    assign w_sum_hi   = w_cap_dw + w_mb_dw;
    assign w_neg_filt = r_filt[DW-1] ? r_filt : '0;
    assign w_lim_v    = r_boost ? (w_cap_dw + w_bb_dw + w_neg_filt) : r_hbp;
    assign w_lim_hi   = CAP_MAX_P + w_bb_dw;

    always_comb begin
        if (w_lim_v < r_lomin) begin
            w_lim = r_lomin;
        end else if (w_lim_v > w_lim_hi) begin
            w_lim = w_lim_hi;
        end else begin
            w_lim = w_lim_v;
        end
    end

    // Sequencer, datapath and configuration next state.
    always_comb begin
        n_busy           = r_busy;
        n_pc             = r_pc;
        n_out_valid      = r_out_valid && !o_out.ready;
        n_out_data       = r_out_data;
        n_loop_gain      = r_loop_gain;
        n_energy_target  = r_energy_target;
        n_rise_alpha     = r_rise_alpha;
        n_fall_alpha     = r_fall_alpha;
        n_max_bonus      = r_max_bonus;
        n_booster_bonus  = r_booster_bonus;
        n_min_power_coef = r_min_power_coef;
        n_offline_coef   = r_offline_coef;
        n_cap            = r_cap;
        n_filt           = r_filt;
        n_hbp            = r_hbp;
        n_prod           = r_prod;
        n_err            = r_err;
        n_lo             = r_lo;
        n_tgt            = r_tgt;
        n_lomin          = r_lomin;
        n_online         = r_online;
        n_boost          = r_boost;

        if (w_accept) begin
            // Load the item: clamp and take the cap when online, and look up both square roots.
            n_busy   = 1'b1;
            n_pc     = UC_CHECK;
            n_online = i_in.data.link_online;
            n_boost  = i_in.data.booster_active;
            if (i_in.data.link_online) begin
                n_cap = {w_cap_w, {FRAC_BITS{1'b0}}};
            end
            n_err = $signed({1'b0, ROOT_TAB[w_energy]})
                  - $signed({1'b0, ROOT_TAB[w_target_idx]});
        end else if (r_busy && !w_stall) begin
            if (w_uw.mul != MUL_NONE) begin
                n_prod = w_prod;
            end

            unique case (w_uw.alu)
                ALU_NONE: begin
                end
                ALU_LOADJ: begin
                    // Lowest adjustment: cap times the minimum coefficient, less the cap.
                    n_lo = DW'(w_shr16) - w_cap_dw;
                end
                ALU_TARGET: begin
                    if (w_tw < w_lo_pw) begin
                        n_tgt = r_lo;
                    end else if (w_tw > w_mb_pw) begin
                        n_tgt = w_mb_dw;
                    end else begin
                        n_tgt = DW'(w_tw);
                    end
                end
                ALU_FILT: begin
                    n_filt = r_filt + DW'(w_step_pw);
                end
                ALU_HBP_ON: begin
                    if (w_sum < w_sum_lo) begin
                        n_hbp = w_sum_lo;
                    end else if (w_sum > w_sum_hi) begin
                        n_hbp = w_sum_hi;
                    end else begin
                        n_hbp = w_sum;
                    end
                end
                ALU_OFF: begin
                    // Offline: derate the held cap and align the filter to it.
                    n_hbp  = DW'(w_shr16);
                    n_filt = DW'(w_shr16) - w_cap_dw;
                end
                ALU_LOMIN: begin
                    n_lomin = DW'(w_shr16);
                end
                ALU_LIMIT: begin
                    n_out_valid                  = 1'b1;
                    n_out_data.drive_power_limit = w_lim[16:0];
                    n_out_data.base_power_cap    = w_cap_dw[14:0];
                    n_out_data.buffered_power    = r_hbp[15:0];
                end
                default: begin
                end
            endcase

            unique case (w_uw.jmp)
                JMP_NEXT:       n_pc = r_pc + PC_W'(1);
                JMP_GOTO:       n_pc = w_uw.dest;
                JMP_IF_OFFLINE: n_pc = r_online ? (r_pc + PC_W'(1)) : w_uw.dest;
                JMP_DONE: begin
                    n_pc   = UC_CHECK;
                    n_busy = 1'b0;
                end
                default:        n_pc = UC_CHECK;
            endcase
        end

        // Configuration writes, each register masked to its width.
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_LOOP_GAIN:      n_loop_gain      = i_cfg_data;
                REG_ENERGY_TARGET:  n_energy_target  = i_cfg_data[5:0];
                REG_RISE_ALPHA:     n_rise_alpha     = i_cfg_data;
                REG_FALL_ALPHA:     n_fall_alpha     = i_cfg_data;
                REG_MAX_BONUS:      n_max_bonus      = i_cfg_data[14:0];
                REG_BOOSTER_BONUS:  n_booster_bonus  = i_cfg_data;
                REG_MIN_POWER_COEF: n_min_power_coef = i_cfg_data;
                REG_OFFLINE_COEF:   n_offline_coef   = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control, configuration and block state, with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy           <= 1'b0;
            r_pc             <= UC_CHECK;
            r_out_valid      <= 1'b0;
            r_loop_gain      <= LOOP_GAIN_RST;
            r_energy_target  <= ENERGY_TARGET_RST;
            r_rise_alpha     <= RISE_ALPHA_RST;
            r_fall_alpha     <= FALL_ALPHA_RST;
            r_max_bonus      <= MAX_BONUS_RST;
            r_booster_bonus  <= BOOSTER_BONUS_RST;
            r_min_power_coef <= MIN_POWER_COEF_RST;
            r_offline_coef   <= OFFLINE_COEF_RSTV;
            r_cap            <= CAP_RESET;
            r_filt           <= FILT_RESET;
            r_hbp            <= HBP_RESET;
        end else begin
            r_busy           <= n_busy;
            r_pc             <= n_pc;
            r_out_valid      <= n_out_valid;
            r_loop_gain      <= n_loop_gain;
            r_energy_target  <= n_energy_target;
            r_rise_alpha     <= n_rise_alpha;
            r_fall_alpha     <= n_fall_alpha;
            r_max_bonus      <= n_max_bonus;
            r_booster_bonus  <= n_booster_bonus;
            r_min_power_coef <= n_min_power_coef;
            r_offline_coef   <= n_offline_coef;
            r_cap            <= n_cap;
            r_filt           <= n_filt;
            r_hbp            <= n_hbp;
        end
    end

    // Datapath and output payload registers.
    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_err      <= n_err;
        r_lo       <= n_lo;
        r_tgt      <= n_tgt;
        r_lomin    <= n_lomin;
        r_online   <= n_online;
        r_boost    <= n_boost;
        r_out_data <= n_out_data;
    end

    // An accepted item starts the program at its first step.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_busy && r_pc == UC_CHECK))
        else $error("accepted item did not start the control program");

    // A result appears only as the end of a running program.
    a_out_from_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result appeared without a running program");

    // The final step frees the sequencer and fills the output register.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_uw.jmp == JMP_DONE && !w_stall) |=> (!r_busy && r_out_valid))
        else $error("final step did not deliver its result");

    // The step counter stays inside the program.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= UC_LIMIT))
        else $error("step counter left the program");

    // The buffered power is never negative while the block is idle.
    a_hbp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !r_hbp[DW-1])
        else $error("buffered power went negative");

endmodule
